// ===== sv/mtwm_pkg.sv =====
// shared types, constants and codes for the multi-track window min/max block
`default_nettype none

package mtwm_pkg;

  // default sizing
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int TRACK_COUNT_DEF = 4;

  // fixed field widths
  localparam int SPAN_REGS = 4;
  localparam int SPAN_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int EXT_W     = 17;
  localparam int FILL_W    = 9;
  localparam int WLEN_W    = 9;
  localparam int TRACK_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // register reset values
  localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd250;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd360;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WLEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN3 = 3'd4;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef logic [SPAN_REGS-1:0][SPAN_W-1:0] span_vec_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming item
    logic apply;   // decide and update track state
    logic step;    // issue one window read
    logic commit;  // store the rescanned extremes
    logic emit;    // load the result register
  } mtwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;  // full window, a rescan follows
    logic scan_last;  // the read being issued is the last one
  } mtwm_status_t;

endpackage

`default_nettype wire

// ===== sv/mtwm_ctrl.sv =====
// sequencing state machine for the window min/max block
`default_nettype none

module mtwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  mtwm_pkg::mtwm_status_t status,
  output mtwm_pkg::mtwm_cmd_t    cmd
);
  import mtwm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_OUTPUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.apply  = (state == ST_EVAL);
    cmd.step   = (state == ST_SCAN);
    cmd.commit = (state == ST_COMMIT);
    cmd.emit   = (state == ST_OUTPUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= status.need_scan ? ST_SCAN : ST_OUTPUT;
        end
        ST_SCAN: begin
          if (status.scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state <= ST_OUTPUT;
        end
        ST_OUTPUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/mtwm_dpath.sv =====
// track state, sample memory, window rescan and result register
`default_nettype none

module mtwm_dpath #(
  parameter int WINDOW_MAX  = mtwm_pkg::WINDOW_MAX_DEF,
  parameter int TRACK_COUNT = mtwm_pkg::TRACK_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mtwm_pkg::mtwm_cmd_t                 cmd,
  output mtwm_pkg::mtwm_status_t              status,
  input  mtwm_pkg::opcode_t                   in_opcode,
  input  logic [mtwm_pkg::TRACK_W-1:0]        in_track,
  input  logic signed [mtwm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [mtwm_pkg::WLEN_W-1:0]         wlen,
  input  mtwm_pkg::span_vec_t                 spans,
  output logic                                res_accepted,
  output logic [mtwm_pkg::TRACK_W-1:0]        res_track,
  output logic signed [mtwm_pkg::EXT_W-1:0]   res_min,
  output logic signed [mtwm_pkg::EXT_W-1:0]   res_max,
  output logic [mtwm_pkg::FILL_W-1:0]         res_fill
);
  import mtwm_pkg::*;

  localparam int PW    = $clog2(WINDOW_MAX);
  localparam int DEPTH = TRACK_COUNT * WINDOW_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = ($clog2(WINDOW_MAX + 1) > WLEN_W) ? $clog2(WINDOW_MAX + 1) : WLEN_W;
  localparam logic [EW:0]   WM_SUM = (EW + 1)'(WINDOW_MAX);
  localparam logic [EW-1:0] WM_LEN = EW'(WINDOW_MAX);
  localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_MAX - 1);
  localparam logic [3:0]    TC_L = 4'(TRACK_COUNT);

  function automatic logic [AW-1:0] addr_of(input logic [TRACK_W-1:0] trk,
                                            input logic [PW-1:0] ptr);
    logic [AW-1:0] base;
    base = AW'(AW'(trk) * AW'(WINDOW_MAX));
    return AW'(base + AW'(ptr));
  endfunction

  // latched item
  opcode_t                   op_q;
  logic [TRACK_W-1:0]        trk_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic                      acc_q;

  // per-track state
  logic [PW-1:0]             oldest [TRACK_COUNT];
  logic [FILL_W-1:0]         held   [TRACK_COUNT];
  logic signed [EXT_W-1:0]   cmin   [TRACK_COUNT];
  logic signed [EXT_W-1:0]   cmax   [TRACK_COUNT];

  // sample memory
  logic [SAMPLE_W-1:0]       mem [DEPTH];
  logic [SAMPLE_W-1:0]       mem_q;

  // rescan
  logic [PW-1:0]             sp;
  logic [FILL_W-1:0]         remain;
  logic                      rd_pend;
  logic                      first;
  logic signed [EXT_W-1:0]   acc_mn;
  logic signed [EXT_W-1:0]   acc_mx;

  // decode of the latched item
  logic                      trk_ok;
  logic [PW-1:0]             sel_old;
  logic [FILL_W-1:0]         sel_held;
  logic signed [EXT_W-1:0]   sel_min;
  logic signed [EXT_W-1:0]   sel_max;
  logic [SPAN_W-1:0]         span_sel;
  logic signed [EXT_W-1:0]   half_s;
  logic signed [EXT_W-1:0]   s_ext;
  logic signed [EXT_W-1:0]   mem_ext;
  logic signed [EXT_W-1:0]   span_pos;
  logic                      in_range;
  logic [EW-1:0]             wl_e;
  logic [EW-1:0]             eff;
  logic                      room;
  logic [EW:0]               pos_sum;
  logic [EW:0]               pos_wrap;
  logic [PW-1:0]             wpos;
  logic [PW-1:0]             old_inc;
  logic [PW-1:0]             sp_inc;
  logic                      do_write;

  assign trk_ok = ({2'b00, trk_q} < TC_L);

  always_comb begin
    sel_old  = '0;
    sel_held = '0;
    sel_min  = '0;
    sel_max  = '0;
    for (int i = 0; i < TRACK_COUNT; i++) begin
      if ({2'b00, trk_q} == 4'(i)) begin
        sel_old  = oldest[i];
        sel_held = held[i];
        sel_min  = cmin[i];
        sel_max  = cmax[i];
      end
    end
  end

  assign span_sel = spans[trk_q];
  assign span_pos = signed'({1'b0, span_sel});
  assign half_s   = signed'({2'b00, span_sel[SPAN_W-1:1]});
  assign s_ext    = {smp_q[SAMPLE_W-1], smp_q};
  assign mem_ext  = {mem_q[SAMPLE_W-1], mem_q};
  assign in_range = (s_ext >= -half_s) && (s_ext <= half_s);

  // effective length is saturated to 1..WINDOW_MAX
  assign wl_e = EW'(wlen);
  always_comb begin
    if (wlen == '0) begin
      eff = EW'(1);
    end else if (wl_e > WM_LEN) begin
      eff = WM_LEN;
    end else begin
      eff = wl_e;
    end
  end

  assign room     = (EW'(sel_held) < eff);
  assign pos_sum  = (EW + 1)'(sel_old) + (EW + 1)'(sel_held);
  assign pos_wrap = (pos_sum >= WM_SUM) ? pos_sum - WM_SUM : pos_sum;
  assign wpos     = pos_wrap[PW-1:0];
  assign old_inc  = (sel_old == PTR_LAST) ? '0 : sel_old + PW'(1);
  assign sp_inc   = (sp == PTR_LAST) ? '0 : sp + PW'(1);
  assign do_write = trk_ok && (op_q == OP_ADD) && in_range;

  assign status.need_scan = do_write && !room;
  assign status.scan_last = (remain == FILL_W'(1));

  // item latch, rescan accumulators and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_opcode;
      trk_q <= in_track;
      smp_q <= in_sample;
    end
    if (cmd.apply) begin
      acc_q <= trk_ok && ((op_q == OP_CLEAR) || in_range);
    end
    if (rd_pend) begin
      if (first) begin
        acc_mn <= mem_ext;
        acc_mx <= mem_ext;
      end else begin
        if (mem_ext < acc_mn) acc_mn <= mem_ext;
        if (mem_ext > acc_mx) acc_mx <= mem_ext;
      end
    end
    if (cmd.emit) begin
      res_accepted <= acc_q;
      res_track    <= trk_q;
      res_min      <= trk_ok ? sel_min : '0;
      res_max      <= trk_ok ? sel_max : '0;
      res_fill     <= trk_ok ? sel_held : '0;
    end
  end

  // track state and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        oldest[i] <= '0;
        held[i]   <= '0;
        if (i < SPAN_REGS) begin
          cmin[i] <= signed'({1'b0, SPAN_RESET});
          cmax[i] <= -signed'({1'b0, SPAN_RESET});
        end else begin
          cmin[i] <= '0;
          cmax[i] <= '0;
        end
      end
      sp      <= '0;
      remain  <= '0;
      rd_pend <= 1'b0;
      first   <= 1'b0;
    end else begin
      rd_pend <= cmd.step;
      if (rd_pend) begin
        first <= 1'b0;
      end
      if (cmd.apply && trk_ok) begin
        for (int i = 0; i < TRACK_COUNT; i++) begin
          if ({2'b00, trk_q} == 4'(i)) begin
            if (op_q == OP_CLEAR) begin
              held[i]   <= '0;
              oldest[i] <= '0;
              cmin[i]   <= span_pos;
              cmax[i]   <= -span_pos;
            end else if (in_range) begin
              if (room) begin
                held[i] <= sel_held + FILL_W'(1);
                if (s_ext > sel_max) cmax[i] <= s_ext;
                if (s_ext < sel_min) cmin[i] <= s_ext;
              end else begin
                oldest[i] <= old_inc;
              end
            end
          end
        end
      end
      if (cmd.apply && status.need_scan) begin
        sp     <= old_inc;
        remain <= sel_held;
        first  <= 1'b1;
      end
      if (cmd.step) begin
        sp     <= sp_inc;
        remain <= remain - FILL_W'(1);
      end
      if (cmd.commit) begin
        for (int i = 0; i < TRACK_COUNT; i++) begin
          if ({2'b00, trk_q} == 4'(i)) begin
            cmin[i] <= acc_mn;
            cmax[i] <= acc_mx;
          end
        end
      end
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.apply && do_write) begin
      mem[addr_of(trk_q, wpos)] <= smp_q;
    end
    if (cmd.step) begin
      mem_q <= mem[addr_of(trk_q, sp)];
    end
  end

endmodule

`default_nettype wire

// ===== sv/multi_track_window_min_max.sv =====
// top level of the multi-track sliding window min/max tracker
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: opcode, track; tdata: sample
//  m_axis    out  m_axis_tvalid/m_axis_tready    tuser: accepted, track_out;
//                                                tdata: window_min, window_max, fill_level
//  cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data (always ready)
//
// one item at a time: a clear, a reject, an add into a window with room or an
// unknown track goes from accept through the evaluate and output states to the result
// an add into a full window rescans the held samples through the single read
// port of the sample memory, one read per held sample, then drain, commit and output
// the result sits in an output register, the next item is taken while it waits
// synchronous reset puts every track in the cleared state and restores the
// register defaults; the sample memory is not cleared and needs no sweep
`default_nettype none

module multi_track_window_min_max #(
  parameter int WINDOW_MAX  = mtwm_pkg::WINDOW_MAX_DEF,
  parameter int TRACK_COUNT = mtwm_pkg::TRACK_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,   // [15:0] sample
  input  logic [2:0]                       s_axis_tuser,   // [0] opcode, [2:1] track
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,   // [16:0] window_min,
                                                           // [33:17] window_max,
                                                           // [42:34] fill_level, rest zero
  output logic [2:0]                       m_axis_tuser,   // [0] accepted, [2:1] track_out
  // register writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mtwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtwm_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import mtwm_pkg::*;

  // configuration registers
  logic [WLEN_W-1:0] wlen;
  span_vec_t         spans;

  mtwm_cmd_t         cmd;
  mtwm_status_t      status;

  logic                      res_accepted;
  logic [TRACK_W-1:0]        res_track;
  logic signed [EXT_W-1:0]   res_min;
  logic signed [EXT_W-1:0]   res_max;
  logic [FILL_W-1:0]         res_fill;

  // writes must only come while idle, the block does not enforce this; the port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen  <= WLEN_RESET;
      spans <= {SPAN_REGS{SPAN_RESET}};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WLEN:  wlen     <= cfg_data[WLEN_W-1:0];
        CFG_SPAN0: spans[0] <= cfg_data[SPAN_W-1:0];
        CFG_SPAN1: spans[1] <= cfg_data[SPAN_W-1:0];
        CFG_SPAN2: spans[2] <= cfg_data[SPAN_W-1:0];
        CFG_SPAN3: spans[3] <= cfg_data[SPAN_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  mtwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mtwm_dpath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .TRACK_COUNT (TRACK_COUNT)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_opcode    (opcode_t'(s_axis_tuser[0])),
    .in_track     (s_axis_tuser[2:1]),
    .in_sample    (s_axis_tdata),
    .wlen         (wlen),
    .spans        (spans),
    .res_accepted (res_accepted),
    .res_track    (res_track),
    .res_min      (res_min),
    .res_max      (res_max),
    .res_fill     (res_fill)
  );

  // result packing
  assign m_axis_tdata = {5'b00000, res_fill, res_max, res_min};
  assign m_axis_tuser = {res_track, res_accepted};

endmodule

`default_nettype wire

// ===== sv/mtwm_checker.sv =====
// port-level checks for the window min/max block and their binding
`default_nettype none

module mtwm_checker #(
  parameter int TRACK_COUNT = mtwm_pkg::TRACK_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  localparam logic [3:0] TC_L = 4'(TRACK_COUNT);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // a non-empty window never reports min above max
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[42:34] != 9'd0)
      |-> $signed(m_axis_tdata[16:0]) <= $signed(m_axis_tdata[33:17]))
    else $error("window min above window max");

  // an absent track reports all zero and not accepted
  a_absent_track: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ({2'b00, m_axis_tuser[2:1]} >= TC_L)
      |-> (m_axis_tdata[42:0] == 43'd0) && !m_axis_tuser[0])
    else $error("absent track gave a nonzero result");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind multi_track_window_min_max mtwm_checker #(
  .TRACK_COUNT (TRACK_COUNT)
) u_mtwm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
